### design/pdvj_pkg.sv
// ----------------------------------------------------------------------------
// pdvj_pkg
// Shared types, register indexes and saturating Q16.16 helpers for the
// jerk-limited PD velocity axis.
// ----------------------------------------------------------------------------
`default_nettype none

package pdvj_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RegW  = 31;
  localparam int unsigned ModeW = 5;
  localparam int unsigned AddrW = 3;
  localparam int unsigned ProdW = 64;

  typedef enum logic [AddrW-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_D_RATE = 3'd1,
    REG_MIN_SPEED   = 3'd2,
    REG_MAX_SPEED   = 3'd3,
    REG_MAX_VEL_STEP = 3'd4,
    REG_MAX_ACC_STEP = 3'd5,
    REG_MODE        = 3'd6
  } reg_idx_t;

  // mode bit positions
  localparam int unsigned ModeP    = 0;
  localparam int unsigned ModeD    = 1;
  localparam int unsigned ModeClip = 2;
  localparam int unsigned ModeAcc  = 3;
  localparam int unsigned ModeJerk = 4;

  typedef struct packed {
    logic [RegW-1:0]  gain_p;
    logic [RegW-1:0]  gain_d_rate;
    logic [RegW-1:0]  min_speed;
    logic [RegW-1:0]  max_speed;
    logic [RegW-1:0]  max_velocity_step;
    logic [RegW-1:0]  max_accel_step;
    logic [ModeW-1:0] mode;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    gain_p:            31'd65536,
    gain_d_rate:       31'd0,
    min_speed:         31'd0,
    max_speed:         31'd65536,
    max_velocity_step: 31'd66,
    max_accel_step:    31'd1,
    mode:              5'd31
  };

  function automatic logic signed [DataW-1:0] sat34(input logic signed [33:0] v);
    logic signed [DataW-1:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  // gain * value product, round half up, drop 16 fraction bits, saturate
  function automatic logic signed [DataW-1:0] qround(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    logic signed [47:0]      q;
    logic signed [DataW-1:0] r;
    s = p + 64'sd32768;
    q = s[63:16];
    if (q > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (q < -48'sh0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = q[DataW-1:0];
    end
    return r;
  endfunction

  function automatic logic [33:0] abs33(input logic signed [32:0] v);
    logic signed [33:0] w;
    w = {v[32], v};
    return v[32] ? 34'(-w) : 34'(w);
  endfunction

  function automatic logic signed [DataW-1:0] speed_clip(
    input logic signed [DataW-1:0] v,
    input logic [RegW-1:0]         lo,
    input logic [RegW-1:0]         hi
  );
    logic [33:0]             a;
    logic signed [DataW-1:0] r;
    a = abs33({v[DataW-1], v});
    if (a < {3'b0, lo}) begin
      r = '0;
    end else if (a > {3'b0, hi}) begin
      r = v[DataW-1] ? -$signed({1'b0, hi}) : $signed({1'b0, hi});
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] limit_mag(
    input logic signed [DataW-1:0] v,
    input logic [RegW-1:0]         lim
  );
    logic [33:0]             a;
    logic signed [DataW-1:0] r;
    a = abs33({v[DataW-1], v});
    if (a > {3'b0, lim}) begin
      r = v[DataW-1] ? -$signed({1'b0, lim}) : $signed({1'b0, lim});
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/pd_velocity_with_jerk_limit.sv
// ----------------------------------------------------------------------------
// pd_velocity_with_jerk_limit
// One axis of a jerk-limited PD velocity controller, signed Q16.16.
// ----------------------------------------------------------------------------
// Takes one control tick per clock while the result register is empty or
// being read, and returns one velocity command per tick. Stages: error
// difference, the two gain multiplies, sum and first speed clip, then the
// velocity loop (accel limit, jerk limit, second clip) whose held velocity
// and step load together with the result register. The whole pipeline moves
// whenever the result register is empty or being read. No item is taken
// while reset is held. The user must write registers only while no item is
// in flight; the block itself does not enforce this.
`default_nettype none

module pd_velocity_with_jerk_limit
  import pdvj_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [AddrW-1:0]  cfg_addr,
  input  wire logic [RegW-1:0]   cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [DataW-1:0]  in_tdata,   // [31:0] axis_error
  input  wire logic              in_tuser,   // [0] tracking_ok
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [DataW-1:0]       out_tdata   // [31:0] velocity_cmd
);

  cfg_t                    cfg_r;
  logic                    adv;
  logic                    raw_valid, res_valid;
  logic signed [DataW-1:0] raw_vel, res_vel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_GAIN_P:       cfg_r.gain_p            <= cfg_wdata;
        REG_GAIN_D_RATE:  cfg_r.gain_d_rate       <= cfg_wdata;
        REG_MIN_SPEED:    cfg_r.min_speed         <= cfg_wdata;
        REG_MAX_SPEED:    cfg_r.max_speed         <= cfg_wdata;
        REG_MAX_VEL_STEP: cfg_r.max_velocity_step <= cfg_wdata;
        REG_MAX_ACC_STEP: cfg_r.max_accel_step    <= cfg_wdata;
        REG_MODE:         cfg_r.mode              <= cfg_wdata[ModeW-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = !res_valid || out_tready;
  assign in_tready = adv && rst_n;

  pdvj_raw u_raw (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_err    ($signed(in_tdata)),
    .in_trk    (in_tuser),
    .raw_valid (raw_valid),
    .raw_vel   (raw_vel)
  );

  pdvj_slew u_slew (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cfg       (cfg_r),
    .raw_valid (raw_valid),
    .raw_vel   (raw_vel),
    .res_valid (res_valid),
    .res_vel   (res_vel)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = res_vel;

endmodule

`default_nettype wire

### design/pdvj_raw.sv
// ----------------------------------------------------------------------------
// pdvj_raw
// Front pipeline: error difference, P and D products, sum and first speed
// clip. Produces the raw velocity request, three stages deep.
// ----------------------------------------------------------------------------
`default_nettype none

module pdvj_raw
  import pdvj_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    adv,
  input  wire cfg_t                    cfg,
  input  wire logic                    in_valid,
  input  wire logic signed [DataW-1:0] in_err,
  input  wire logic                    in_trk,
  output logic                         raw_valid,
  output logic signed [DataW-1:0]      raw_vel
);

  logic                    last_err_valid_unused;
  logic signed [DataW-1:0] last_err_r;

  logic                    s1_vld_r, s2_vld_r, s3_vld_r;
  logic signed [DataW-1:0] s1_err_r, s1_diff_r;
  logic                    s1_trk_r, s2_trk_r;
  logic signed [ProdW-1:0] s2_pp_r, s2_pd_r;
  logic signed [DataW-1:0] s3_raw_r;

  logic signed [DataW-1:0] diff_nxt;
  logic signed [DataW-1:0] term_p, term_d, raw_nxt;
  logic signed [32:0]      acc;

  assign last_err_valid_unused = 1'b0;
  assign diff_nxt = sat34(34'(in_err) - 34'(last_err_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      if (in_valid && in_trk) begin
        last_err_r <= in_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_err_r  <= in_err;
      s1_diff_r <= diff_nxt;
      s1_trk_r  <= in_trk;
      s2_pp_r   <= $signed({1'b0, cfg.gain_p}) * s1_err_r;
      s2_pd_r   <= $signed({1'b0, cfg.gain_d_rate}) * s1_diff_r;
      s2_trk_r  <= s1_trk_r;
      s3_raw_r  <= raw_nxt;
    end
  end

  always_comb begin
    term_p  = cfg.mode[ModeP] ? qround(s2_pp_r) : '0;
    term_d  = cfg.mode[ModeD] ? qround(s2_pd_r) : '0;
    acc     = 33'(term_p) + 33'(term_d);
    raw_nxt = sat34(34'(acc));
    if (cfg.mode[ModeClip]) begin
      raw_nxt = speed_clip(raw_nxt, cfg.min_speed, cfg.max_speed);
    end
    if (!s2_trk_r || last_err_valid_unused) begin
      raw_nxt = '0;
    end
  end

  assign raw_valid = s3_vld_r;
  assign raw_vel   = s3_raw_r;

endmodule

`default_nettype wire

### design/pdvj_slew.sv
// ----------------------------------------------------------------------------
// pdvj_slew
// Velocity loop: acceleration and jerk limiting against the held velocity
// and step, second speed clip, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdvj_slew
  import pdvj_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    adv,
  input  wire cfg_t                    cfg,
  input  wire logic                    raw_valid,
  input  wire logic signed [DataW-1:0] raw_vel,
  output logic                         res_valid,
  output logic signed [DataW-1:0]      res_vel
);

  logic signed [DataW-1:0] last_vel_r, last_step_r, vel_r;
  logic                    vld_r;

  logic signed [DataW-1:0] step, vel;
  logic signed [32:0]      jerk, jstep;
  logic [33:0]             jabs;

  always_comb begin
    step = sat34(34'(raw_vel) - 34'(last_vel_r));
    if (cfg.mode[ModeAcc]) begin
      step = limit_mag(step, cfg.max_velocity_step);
    end
    jerk  = 33'(step) - 33'(last_step_r);
    jabs  = abs33(jerk);
    jstep = jerk[32] ? 33'(last_step_r) - 33'({2'b0, cfg.max_accel_step})
                     : 33'(last_step_r) + 33'({2'b0, cfg.max_accel_step});
    if (cfg.mode[ModeJerk] && (jabs > {3'b0, cfg.max_accel_step})) begin
      step = sat34(34'(jstep));
    end
    vel = sat34(34'(last_vel_r) + 34'(step));
    if (cfg.mode[ModeClip]) begin
      vel = speed_clip(vel, cfg.min_speed, cfg.max_speed);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_vel_r  <= '0;
      last_step_r <= '0;
      vld_r       <= 1'b0;
    end else if (adv) begin
      vld_r <= raw_valid;
      if (raw_valid) begin
        last_vel_r  <= vel;
        last_step_r <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vel_r <= vel;
    end
  end

  assign res_valid = vld_r;
  assign res_vel   = vel_r;

endmodule

`default_nettype wire

### sim/pd_velocity_with_jerk_limit_tb.sv
// ----------------------------------------------------------------------------
// pd_velocity_with_jerk_limit_tb
// Self-checking bench for the jerk-limited PD velocity axis: a queue-fed
// driver sends control ticks, a local Q16.16 predictor computes each
// expected velocity command, and a monitor compares results in order.
// Covers directed corner settings, then random settings and error streams
// under varying back-pressure, including one long output stall.
// ----------------------------------------------------------------------------
module pd_velocity_with_jerk_limit_tb;
  import pdvj_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CycleLimit  = 400000;
  localparam int          DrainCycles = 16;
  localparam int          HoldCycles  = 400;
  localparam int          RandPhases  = 8;
  localparam int          PhaseItems  = 190;
  localparam logic [AddrW-1:0] RegUnused = 3'd7;
  localparam logic [RegW-1:0]  RegFull   = 31'h7FFF_FFFF;
  localparam logic [RegW-1:0]  QOne      = 31'd65536;
  localparam logic [ModeW-1:0] EnP    = 5'(1 << ModeP);
  localparam logic [ModeW-1:0] EnD    = 5'(1 << ModeD);
  localparam logic [ModeW-1:0] EnClip = 5'(1 << ModeClip);
  localparam logic [ModeW-1:0] EnAcc  = 5'(1 << ModeAcc);
  localparam logic [ModeW-1:0] EnJerk = 5'(1 << ModeJerk);
  localparam logic [ModeW-1:0] EnAll  = EnP | EnD | EnClip | EnAcc | EnJerk;
  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;

  typedef struct packed {
    logic [DataW-1:0] err;
    logic             trk;
  } tick_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             cfg_wr_en  = 1'b0;
  logic [AddrW-1:0] cfg_addr   = '0;
  logic [RegW-1:0]  cfg_wdata  = '0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [DataW-1:0] in_tdata   = '0;   // [31:0] axis_error
  logic             in_tuser   = 1'b0; // [0] tracking_ok
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [DataW-1:0] out_tdata;         // [31:0] velocity_cmd

  tick_t            tick_q[$];
  tick_t            cur_tick;
  logic [DataW-1:0] vel_exp_q[$];
  int               src_idle_pct = 0;
  int               snk_idle_pct = 0;
  int               hold_left    = 0;
  logic             hold_go      = 1'b0;
  int               cycles       = 0;
  int               errors       = 0;

  // predictor copy of registers and loop state
  longint           k_p    = longint'(CfgReset.gain_p);
  longint           k_d    = longint'(CfgReset.gain_d_rate);
  longint           spd_lo = longint'(CfgReset.min_speed);
  longint           spd_hi = longint'(CfgReset.max_speed);
  longint           dv_lim = longint'(CfgReset.max_velocity_step);
  longint           da_lim = longint'(CfgReset.max_accel_step);
  logic [ModeW-1:0] mode_bits = CfgReset.mode;
  longint           prev_err = 0;
  longint           prev_vel = 0;
  longint           prev_dv  = 0;

  pd_velocity_with_jerk_limit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint clamp32(longint v);
    if (v > S32Max) return S32Max;
    if (v < S32Min) return S32Min;
    return v;
  endfunction

  // Q16.16 gain times value, round half up, saturate
  function automatic longint q16_mul(longint g, longint x);
    longint p;
    p = g * x + 64'sd32768;
    return clamp32(p >>> 16);
  endfunction

  function automatic longint deadband_clip(longint v);
    longint a;
    a = (v < 0) ? -v : v;
    if (a < spd_lo) return 0;
    if (a > spd_hi) return (v < 0) ? -spd_hi : spd_hi;
    return v;
  endfunction

  function automatic longint mag_limit(longint v, longint lim);
    longint a;
    a = (v < 0) ? -v : v;
    if (a > lim) return (v < 0) ? -lim : lim;
    return v;
  endfunction

  function automatic logic [DataW-1:0] velocity_predict(tick_t t);
    longint e, acc, raw, dv, jk, vel;
    e   = longint'($signed(t.err));
    raw = 0;
    if (t.trk) begin
      acc = 0;
      if (mode_bits[ModeP]) acc += q16_mul(k_p, e);
      if (mode_bits[ModeD]) acc += q16_mul(k_d, clamp32(e - prev_err));
      raw = clamp32(acc);
      if (mode_bits[ModeClip]) raw = deadband_clip(raw);
      prev_err = e;
    end
    dv = clamp32(raw - prev_vel);
    if (mode_bits[ModeAcc]) dv = mag_limit(dv, dv_lim);
    if (mode_bits[ModeJerk]) begin
      jk = dv - prev_dv;
      if (((jk < 0) ? -jk : jk) > da_lim)
        dv = clamp32(prev_dv + ((jk < 0) ? -da_lim : da_lim));
    end
    vel = clamp32(prev_vel + dv);
    if (mode_bits[ModeClip]) vel = deadband_clip(vel);
    prev_dv  = dv;
    prev_vel = vel;
    return vel[DataW-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) vel_exp_q.push_back(velocity_predict(cur_tick));
      if (!in_tvalid || in_tready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_tick = tick_q.pop_front();
          in_tdata  <= cur_tick.err;
          in_tuser  <= cur_tick.trk;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long output stall counter
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      hold_left <= HoldCycles;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [DataW-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (vel_exp_q.size() == 0) begin
        report_mismatch($sformatf("velocity_cmd %0d with nothing expected",
                                  $signed(out_tdata)));
      end else begin
        want = vel_exp_q.pop_front();
        if (out_tdata !== want)
          report_mismatch($sformatf("velocity_cmd got %0d want %0d",
                                    $signed(out_tdata), $signed(want)));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic cfg_write(input logic [AddrW-1:0] addr, input logic [RegW-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    case (addr)
      REG_GAIN_P:       k_p = longint'(val);
      REG_GAIN_D_RATE:  k_d = longint'(val);
      REG_MIN_SPEED:    spd_lo = longint'(val);
      REG_MAX_SPEED:    spd_hi = longint'(val);
      REG_MAX_VEL_STEP: dv_lim = longint'(val);
      REG_MAX_ACC_STEP: da_lim = longint'(val);
      REG_MODE:         mode_bits = val[ModeW-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic cfg_all(input logic [RegW-1:0] gp, input logic [RegW-1:0] gd,
                         input logic [RegW-1:0] lo, input logic [RegW-1:0] hi,
                         input logic [RegW-1:0] dv, input logic [RegW-1:0] da,
                         input logic [ModeW-1:0] m);
    cfg_write(REG_GAIN_P, gp);
    cfg_write(REG_GAIN_D_RATE, gd);
    cfg_write(REG_MIN_SPEED, lo);
    cfg_write(REG_MAX_SPEED, hi);
    cfg_write(REG_MAX_VEL_STEP, dv);
    cfg_write(REG_MAX_ACC_STEP, da);
    cfg_write(REG_MODE, {{(RegW-ModeW){1'b0}}, m});
  endtask

  task automatic queue_tick(input int e, input logic trk);
    tick_t t;
    t.err = e;
    t.trk = trk;
    tick_q.push_back(t);
  endtask

  task automatic wait_idle();
    while (tick_q.size() != 0 || in_tvalid || vel_exp_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [RegW-1:0] pick_reg(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return RegFull;
    if (r == 2) return RegW'($urandom);
    return RegW'($urandom_range(hi, lo));
  endfunction

  initial begin
    longint walk;
    int     e;
    int     r;
    walk = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 29;
    snk_idle_pct = 79;

    // reset settings, full-scale errors
    queue_tick(32'h7FFF_FFFF, 1'b1);
    queue_tick(32'h8000_0000, 1'b1);
    queue_tick(0, 1'b0);
    queue_tick(32'h0001_0000, 1'b1);
    wait_idle();

    // speed clip edges: equal to bounds passes, inside deadband drops
    cfg_all(QOne, '0, 31'h1000, 31'h10000, RegFull, RegFull, EnP | EnClip);
    queue_tick(32'h0001_0000, 1'b1);
    queue_tick(32'h0000_1000, 1'b1);
    queue_tick(32'h0000_0FFF, 1'b1);
    queue_tick(32'h0001_0001, 1'b1);
    queue_tick(-32'sh1_0000, 1'b1);
    queue_tick(-32'sh1_0001, 1'b1);
    queue_tick(-32'sh0FFF, 1'b1);
    queue_tick(5, 1'b0);
    wait_idle();

    // deadband above max speed
    cfg_write(REG_MIN_SPEED, 31'h20000);
    queue_tick(32'h0001_FFFF, 1'b1);
    queue_tick(32'h0002_0000, 1'b1);
    queue_tick(-32'sh3_0000, 1'b1);
    wait_idle();

    // max gains, P and D only; error difference saturates; lost tracking
    cfg_all(RegFull, RegFull, '0, RegFull, RegFull, RegFull, EnP | EnD);
    queue_tick(32'h7FFF_FFFF, 1'b1);
    queue_tick(32'h8000_0000, 1'b1);
    queue_tick(32'h7FFF_FFFF, 1'b0);
    queue_tick(-1, 1'b1);
    wait_idle();

    // every register at full scale, plus an ignored index
    cfg_all(RegFull, RegFull, RegFull, RegFull, RegFull, RegFull, EnAll);
    cfg_write(REG_MODE, RegFull);
    cfg_write(RegUnused, 31'h0000_0000);
    queue_tick(32'h1234_5678, 1'b1);
    queue_tick(32'h8000_0000, 1'b1);
    wait_idle();

    // all stages off
    cfg_all('0, '0, '0, '0, '0, '0, '0);
    queue_tick(32'h7FFF_FFFF, 1'b1);
    queue_tick(-5, 1'b1);
    wait_idle();

    // accel and jerk limits on a step
    cfg_all(QOne, '0, '0, RegFull, 31'h100, 31'h10, EnP | EnAcc | EnJerk);
    queue_tick(32'h0010_0000, 1'b1);
    queue_tick(32'h0010_0000, 1'b1);
    wait_idle();

    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph == 3) begin
        src_idle_pct = 79;
        snk_idle_pct = 29;
      end else if (ph == 6) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      cfg_all(pick_reg(0, 31'h30000), pick_reg(0, 31'h8000), pick_reg(0, 31'h4000),
              pick_reg(31'h8000, 31'h100000), pick_reg(31'h10, 31'h8000),
              pick_reg(1, 31'h1000),
              $urandom_range(1) ? EnAll : ModeW'($urandom));
      for (int i = 0; i < PhaseItems; i++) begin
        r = $urandom_range(99);
        if (r < 60) begin
          walk = walk + longint'($urandom_range(32'h8000)) - 64'sd16384;
          if (walk > 64'sd1048576) walk = 64'sd1048576;
          if (walk < -64'sd1048576) walk = -64'sd1048576;
          e = int'(walk);
        end else if (r < 85) begin
          e = $urandom;
        end else begin
          case ($urandom_range(4))
            0: e = 0;
            1: e = 32'h7FFF_FFFF;
            2: e = 32'h8000_0000;
            3: e = 1;
            default: e = -1;
          endcase
        end
        queue_tick(e, $urandom_range(99) < 85);
      end
      if (ph == 6) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
